### sv/bgf_pkg.sv
// bgf_pkg: shared constants, register indexes and the result item type
// for the 3x3 binary gap fill block. no dependencies.
package bgf_pkg;

   localparam int ROW_W      = 64;   // width of the row fields on the ports
   localparam int IDX_W      = 12;   // width of the row_index field
   localparam int RSP_DATA_W = 144;  // 64 + 64 + 12 rounded up to whole bytes
   localparam int COL_W      = 7;    // width of the row_width register
   localparam int HGT_W      = 13;   // width of the frame_height register
   localparam int MRG_W      = 3;    // width of the border_margin register
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam int LANE_W     = 8;    // columns handled by one lane
   localparam int FIFO_DEPTH = 4;    // result queue entries, power of two

   localparam int DEF_MAX_WIDTH       = 64;
   localparam int DEF_MAX_HEIGHT_BITS = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_WIDTH     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BORDER_MARGIN = 2'd2;

   localparam logic [COL_W-1:0] RST_ROW_WIDTH     = 7'd64;
   localparam logic [HGT_W-1:0] RST_FRAME_HEIGHT  = 13'd64;
   localparam logic [MRG_W-1:0] RST_BORDER_MARGIN = 3'd1;

   typedef struct packed {
      logic [ROW_W-1:0] filled_row;
      logic [ROW_W-1:0] gap_mask;
      logic [IDX_W-1:0] row_index;
      logic             frame_last;
   } rsp_item_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

### sv/bgf_lane.sv
// bgf_lane: gap test for one slice of columns of the centre row.
// depends on bgf_pkg for the column counter width.
module bgf_lane #(
   parameter int LANE_BASE = 0,
   parameter int LANE_COLS = bgf_pkg::LANE_W
) (
   input  logic [LANE_COLS+1:0]      up_win,
   input  logic [LANE_COLS+1:0]      mid_win,
   input  logic [LANE_COLS+1:0]      down_win,
   input  logic [bgf_pkg::COL_W-1:0] width_eff,
   input  logic [bgf_pkg::MRG_W-1:0] margin_eff,
   output logic [LANE_COLS-1:0]      gaps
);
   import bgf_pkg::*;

   always_comb begin
      logic             pair_any;
      logic [COL_W:0]   col;
      logic [COL_W:0]   col_end;
      logic             col_ok;
      for (int i = 0; i < LANE_COLS; i++) begin
         pair_any = (mid_win[i] & mid_win[i+2])
                  | (up_win[i+1] & down_win[i+1])
                  | (up_win[i] & down_win[i+2])
                  | (down_win[i] & up_win[i+2])
                  | (up_win[i] & up_win[i+2])
                  | (down_win[i] & down_win[i+2])
                  | (up_win[i] & down_win[i])
                  | (up_win[i+2] & down_win[i+2]);
         col     = (COL_W+1)'(LANE_BASE + i);
         col_end = col + (COL_W+1)'(margin_eff);
         col_ok  = (col >= (COL_W+1)'(margin_eff)) && (col_end < (COL_W+1)'(width_eff));
         gaps[i] = pair_any & ~mid_win[i+1] & col_ok;
      end
   end

endmodule

### sv/bgf_merge.sv
// bgf_merge: joins the lane gap bits and builds the zero, one or two result items
// that an accepted row causes. depends on bgf_pkg.
module bgf_merge #(
   parameter int MAX_WIDTH = bgf_pkg::DEF_MAX_WIDTH,
   parameter int PAD_W     = bgf_pkg::DEF_MAX_WIDTH
) (
   input  logic                      accept,
   input  logic [PAD_W-1:0]          lane_gaps,
   input  logic                      row_on,
   input  logic                      have_centre,
   input  logic                      frame_end,
   input  logic [MAX_WIDTH-1:0]      centre_row,
   input  logic [MAX_WIDTH-1:0]      new_row,
   input  logic [bgf_pkg::IDX_W-1:0] centre_idx,
   input  logic [bgf_pkg::IDX_W-1:0] new_idx,
   output bgf_pkg::rsp_item_type     item0,
   output bgf_pkg::rsp_item_type     item1,
   output bgf_pkg::push_type         push
);
   import bgf_pkg::*;

   logic [MAX_WIDTH-1:0] gaps;
   rsp_item_type         centre_item;
   rsp_item_type         last_item;

   assign gaps = row_on ? lane_gaps[MAX_WIDTH-1:0] : '0;

   always_comb begin
      centre_item.filled_row = ROW_W'(centre_row | gaps);
      centre_item.gap_mask   = ROW_W'(gaps);
      centre_item.row_index  = centre_idx;
      centre_item.frame_last = 1'b0;
      last_item.filled_row   = ROW_W'(new_row);
      last_item.gap_mask     = '0;
      last_item.row_index    = new_idx;
      last_item.frame_last   = 1'b1;
      if (have_centre) begin
         item0       = centre_item;
         item1       = last_item;
         push.first  = accept;
         push.second = accept & frame_end;
      end else begin
         item0       = last_item;
         item1       = last_item;
         push.first  = accept & frame_end;
         push.second = 1'b0;
      end
   end

endmodule

### sv/bgf_fifo.sv
// bgf_fifo: small result queue taking up to two items per cycle and
// giving one while out_ready is high. depends on bgf_pkg.
module bgf_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  bgf_pkg::push_type     push,
   input  bgf_pkg::rsp_item_type item0,
   input  bgf_pkg::rsp_item_type item1,
   output logic                  room_two,
   output logic                  out_valid,
   input  logic                  out_ready,
   output bgf_pkg::rsp_item_type out_item
);
   import bgf_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rsp_item_type     mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign pop       = out_valid & out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem[rd_ff];
   assign room_two  = (cnt_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign wr_next   = wr_ff + PTR_W'(1);

   always_comb begin
      wr_in  = wr_ff + PTR_W'(push.first) + PTR_W'(push.second);
      rd_in  = rd_ff + PTR_W'(pop);
      cnt_in = cnt_ff + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem[wr_ff] <= item0;
      end
      if (push.second) begin
         mem[wr_next] <= item1;
      end
   end

endmodule

### sv/binary_gap_fill_3x3_top.sv
// Binary 3x3 gap filler. One image row (up to MAX_WIDTH pixels) is taken per
// cycle on req_; a row leaves on rsp_ once the row below it has arrived, and
// the final row of a frame leaves right after it, so that row causes two items.
// The gap test for all columns runs in parallel lanes of eight columns in the
// accept cycle and the items go to a four-entry queue; an item can appear on
// rsp_ the cycle after its row is accepted. req_tready stays high while the
// queue has room for two items, so rows stream at one per cycle as long as
// rsp_tready keeps up; the final row of a frame adds one extra output item.
// depends on bgf_pkg, bgf_lane, bgf_merge and bgf_fifo.
module binary_gap_fill_3x3_top #(
   parameter int MAX_WIDTH       = bgf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT_BITS = bgf_pkg::DEF_MAX_HEIGHT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bgf_pkg::ROW_W-1:0]      req_tdata,   // row_bits
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bgf_pkg::RSP_DATA_W-1:0] rsp_tdata,   // filled_row, gap_mask, row_index, zeros
   output logic                           rsp_tlast,   // frame_last
   input  logic                           csr_we,
   input  logic [bgf_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [bgf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bgf_pkg::*;

   localparam int NUM_LANES = (MAX_WIDTH + LANE_W - 1) / LANE_W;
   localparam int PAD_W     = NUM_LANES * LANE_W;
   localparam int HCMP_W    = ((HGT_W > MAX_HEIGHT_BITS + 1) ? HGT_W : MAX_HEIGHT_BITS + 1) + 1;
   localparam int IDXX_W    = MAX_HEIGHT_BITS + IDX_W;

   logic [COL_W-1:0]           width_ff;
   logic [HGT_W-1:0]           height_ff;
   logic [MRG_W-1:0]           margin_ff;
   logic [MAX_WIDTH-1:0]       upper_ff, upper_in;
   logic [MAX_WIDTH-1:0]       centre_ff, centre_in;
   logic [MAX_HEIGHT_BITS-1:0] rows_ff, rows_in;

   logic                       accept;
   logic [COL_W-1:0]           width_eff;
   logic [MRG_W-1:0]           margin_eff;
   logic [HCMP_W-1:0]          height_x;
   logic [HCMP_W-1:0]          height_cap;
   logic [HCMP_W-1:0]          height_eff;
   logic [HCMP_W-1:0]          k_x;
   logic [HCMP_W-1:0]          c_x;
   logic                       have_centre;
   logic                       frame_end;
   logic                       row_on;
   logic [MAX_WIDTH-1:0]       row_m;
   logic [MAX_HEIGHT_BITS-1:0] c_idx;
   logic [IDXX_W-1:0]          c_wide;
   logic [IDXX_W-1:0]          k_wide;
   logic [PAD_W+1:0]           up_pad;
   logic [PAD_W+1:0]           mid_pad;
   logic [PAD_W+1:0]           down_pad;
   logic [PAD_W-1:0]           lane_gaps;
   rsp_item_type               item0;
   rsp_item_type               item1;
   rsp_item_type               out_item;
   push_type                   push;

   assign accept = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_ROW_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
         margin_ff <= RST_BORDER_MARGIN;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROW_WIDTH:     width_ff  <= csr_wdata[COL_W-1:0];
            CSR_FRAME_HEIGHT:  height_ff <= csr_wdata[HGT_W-1:0];
            CSR_BORDER_MARGIN: margin_ff <= csr_wdata[MRG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_eff  = (width_ff > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : width_ff;
      margin_eff = (margin_ff == '0) ? MRG_W'(1) : margin_ff;
      height_x   = HCMP_W'(height_ff);
      height_cap = HCMP_W'(1) << MAX_HEIGHT_BITS;
      if (height_x > height_cap) begin
         height_eff = height_cap;
      end else if (height_x == '0) begin
         height_eff = HCMP_W'(1);
      end else begin
         height_eff = height_x;
      end
      k_x         = HCMP_W'(rows_ff);
      c_x         = k_x - HCMP_W'(1);
      have_centre = (rows_ff != '0);
      frame_end   = (k_x + HCMP_W'(1) >= height_eff);
      row_on      = have_centre && (c_x >= HCMP_W'(margin_eff))
                    && (c_x + HCMP_W'(margin_eff) < height_eff);
      c_idx       = rows_ff - MAX_HEIGHT_BITS'(1);
      c_wide      = IDXX_W'(c_idx);
      k_wide      = IDXX_W'(rows_ff);
      for (int c = 0; c < MAX_WIDTH; c++) begin
         row_m[c] = req_tdata[c] & (COL_W'(c) < width_ff);
      end
      up_pad   = {1'b0, PAD_W'(upper_ff), 1'b0};
      mid_pad  = {1'b0, PAD_W'(centre_ff), 1'b0};
      down_pad = {1'b0, PAD_W'(row_m), 1'b0};
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      bgf_lane #(
         .LANE_BASE (l * LANE_W),
         .LANE_COLS (LANE_W)
      ) u_lane (
         .up_win     (up_pad[l*LANE_W +: LANE_W+2]),
         .mid_win    (mid_pad[l*LANE_W +: LANE_W+2]),
         .down_win   (down_pad[l*LANE_W +: LANE_W+2]),
         .width_eff  (width_eff),
         .margin_eff (margin_eff),
         .gaps       (lane_gaps[l*LANE_W +: LANE_W])
      );
   end

   bgf_merge #(
      .MAX_WIDTH (MAX_WIDTH),
      .PAD_W     (PAD_W)
   ) u_merge (
      .accept      (accept),
      .lane_gaps   (lane_gaps),
      .row_on      (row_on),
      .have_centre (have_centre),
      .frame_end   (frame_end),
      .centre_row  (centre_ff),
      .new_row     (row_m),
      .centre_idx  (c_wide[IDX_W-1:0]),
      .new_idx     (k_wide[IDX_W-1:0]),
      .item0       (item0),
      .item1       (item1),
      .push        (push)
   );

   bgf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .item0     (item0),
      .item1     (item1),
      .room_two  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {(RSP_DATA_W - 2*ROW_W - IDX_W)'(0), out_item.row_index,
                       out_item.gap_mask, out_item.filled_row};
   assign rsp_tlast = out_item.frame_last;

   always_comb begin
      if (accept) begin
         if (frame_end) begin
            upper_in  = '0;
            centre_in = '0;
            rows_in   = '0;
         end else begin
            upper_in  = centre_ff;
            centre_in = row_m;
            rows_in   = rows_ff + MAX_HEIGHT_BITS'(1);
         end
      end else begin
         upper_in  = upper_ff;
         centre_in = centre_ff;
         rows_in   = rows_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= '0;
         centre_ff <= '0;
         rows_ff   <= '0;
      end else begin
         upper_ff  <= upper_in;
         centre_ff <= centre_in;
         rows_ff   <= rows_in;
      end
   end

`ifndef SYNTHESIS
   a_last_no_gaps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2*ROW_W-1:ROW_W] == '0)
      else $error("final row carries gap bits");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> rows_ff == '0)
      else $error("row count not cleared at frame end");

   a_row_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !frame_end |=> rows_ff == $past(rows_ff) + MAX_HEIGHT_BITS'(1))
      else $error("row count did not advance");
`endif

endmodule
